[rtl/core/bpst_pkg.sv]
// shared types and constants of the breakpoint slot table
package bpst_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int HOOK_W   = 32;
  localparam int PCNT_W   = 8;
  localparam int PREF_W   = 32;
  localparam int ACT_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 2;

  // table size default and register reset
  localparam int MAX_SLOTS_DEF = 8;
  localparam logic [ACT_W-1:0] ACTIVE_SLOTS_RST = 4'd8;

  // address handling
  localparam logic [ADDR_W-1:0] ADDR_MASK   = 32'hFFFF_FFFE;
  localparam logic [ADDR_W-1:0] COMP_ENABLE = 32'h0000_0001;

  // operation codes
  localparam logic OP_SET    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SET_DONE  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [HOOK_W-1:0] hook_addr;
    logic [PCNT_W-1:0] patch_count;
    logic [PREF_W-1:0] patch_ref;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] comp_word;
    logic [HOOK_W-1:0] hook_out;
    logic [PCNT_W-1:0] patch_count_out;
    logic [PREF_W-1:0] patch_ref_out;
  } rsp_t;

endpackage

[rtl/core/bpst_if.sv]
// valid/ready channel interfaces of the breakpoint slot table

interface bpst_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bpst_pkg::ADDR_W-1:0] addr;
  logic [bpst_pkg::HOOK_W-1:0] hook_addr;
  logic [bpst_pkg::PCNT_W-1:0] patch_count;
  logic [bpst_pkg::PREF_W-1:0] patch_ref;

  modport source (output valid, op, addr, hook_addr, patch_count, patch_ref, input ready);
  modport sink   (input valid, op, addr, hook_addr, patch_count, patch_ref, output ready);
endinterface

interface bpst_rsp_if;
  logic                         valid;
  logic                         ready;
  bpst_pkg::status_t            status;
  logic [bpst_pkg::SLOT_W-1:0]  slot;
  logic [bpst_pkg::ADDR_W-1:0]  comp_word;
  logic [bpst_pkg::HOOK_W-1:0]  hook_out;
  logic [bpst_pkg::PCNT_W-1:0]  patch_count_out;
  logic [bpst_pkg::PREF_W-1:0]  patch_ref_out;

  modport source (output valid, status, slot, comp_word, hook_out, patch_count_out,
                  patch_ref_out, input ready);
  modport sink   (input valid, status, slot, comp_word, hook_out, patch_count_out,
                  patch_ref_out, output ready);
endinterface

interface bpst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bpst_pkg::ACT_W-1:0]  active_slots;

  modport source (output valid, active_slots, input ready);
  modport sink   (input valid, active_slots, output ready);
endinterface

[rtl/core/bpst_slots.sv]
// slot storage, parallel address compare and allocation of the breakpoint table
module bpst_slots #(
  parameter int MAX_SLOTS = bpst_pkg::MAX_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bpst_pkg::ACT_W-1:0]  active_slots,
  input  bpst_pkg::req_t              req,
  input  logic                        fire,
  output bpst_pkg::rsp_t              rsp
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_A = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W = (CNT_A > bpst_pkg::ACT_W) ? CNT_A : bpst_pkg::ACT_W;

  logic [MAX_SLOTS-1:0]          slot_valid;
  logic [bpst_pkg::ADDR_W-1:0]   slot_addr        [MAX_SLOTS];
  logic [bpst_pkg::HOOK_W-1:0]   slot_hook        [MAX_SLOTS];
  logic [bpst_pkg::PCNT_W-1:0]   slot_patch_count [MAX_SLOTS];
  logic [bpst_pkg::PREF_W-1:0]   slot_patch_ref   [MAX_SLOTS];

  logic [bpst_pkg::ADDR_W-1:0]   key;
  logic [MAX_SLOTS-1:0]          elig;
  logic [MAX_SLOTS-1:0]          free;
  logic [MAX_SLOTS-1:0]          hit;
  logic                          free_any;
  logic [IDX_W-1:0]              free_idx;
  logic                          hit_any;
  logic [IDX_W-1:0]              hit_idx;
  logic                          found;
  logic                          do_write;

  assign key = req.addr & bpst_pkg::ADDR_MASK;

  // per-slot compare against the usable count
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      elig[i] = CNT_W'(i) < CNT_W'(active_slots);
      free[i] = elig[i] & ~slot_valid[i];
      hit[i]  = elig[i] & slot_valid[i] & (slot_addr[i] == key);
    end
  end

  // lowest free slot and lowest hit
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    hit_any  = 1'b0;
    hit_idx  = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // scan stops at the first free slot
  assign found    = hit_any & (~free_any | (hit_idx < free_idx));
  assign do_write = fire & (req.op == bpst_pkg::OP_SET) & free_any;

  always_comb begin
    rsp = '0;
    if (req.op == bpst_pkg::OP_SET) begin
      if (free_any) begin
        rsp.status    = bpst_pkg::ST_SET_DONE;
        rsp.slot      = bpst_pkg::SLOT_W'(free_idx);
        rsp.comp_word = key | bpst_pkg::COMP_ENABLE;
      end else begin
        rsp.status = bpst_pkg::ST_FULL;
      end
    end else begin
      if (found) begin
        rsp.status          = bpst_pkg::ST_FOUND;
        rsp.slot            = bpst_pkg::SLOT_W'(hit_idx);
        rsp.hook_out        = slot_hook[hit_idx];
        rsp.patch_count_out = slot_patch_count[hit_idx];
        rsp.patch_ref_out   = slot_patch_ref[hit_idx];
      end else begin
        rsp.status = bpst_pkg::ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (do_write) begin
      slot_valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_addr[free_idx]        <= key;
      slot_hook[free_idx]        <= req.hook_addr;
      slot_patch_count[free_idx] <= req.patch_count;
      slot_patch_ref[free_idx]   <= req.patch_ref;
    end
  end

endmodule

[rtl/core/breakpoint_slot_table_core.sv]
// top level of the breakpoint slot table: handshake, input and result registers
//
//  channel  modport  role
//  -------  -------  -------------------------------------------------------
//  cfg      sink     write of the active slot count, always ready
//  req      sink     set or lookup request (op, addr, hook_addr, patch data)
//  rsp      source   one result per request (status, slot, comp_word, data)
//
// a request is held in the input register and its result in the result register.
// one request is taken every cycle while rsp stays ready; a set updates the table
// at the same edge that registers its result, so the following request already
// sees it.
// a stall on rsp holds both registers and drops req ready once they are full.
// reset clears the valid marks of all slots and sets the active count to 8.
module breakpoint_slot_table_core #(
  parameter int MAX_SLOTS = bpst_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bpst_cfg_if.sink    cfg,
  bpst_req_if.sink    req,
  bpst_rsp_if.source  rsp
);

  // configuration register
  logic [bpst_pkg::ACT_W-1:0] active_slots;

  // input register
  bpst_pkg::req_t req_q;
  logic           req_q_valid;

  // result register
  bpst_pkg::rsp_t rsp_q;
  logic           rsp_q_valid;

  bpst_pkg::rsp_t rsp_next;
  logic           advance;
  logic           req_xfer;

  // config writes must land only while idle; the block itself does not enforce it
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= bpst_pkg::ACTIVE_SLOTS_RST;
    end else if (cfg.valid) begin
      active_slots <= cfg.active_slots;
    end
  end

  // the working item moves on when the result register is free or drains
  assign advance   = req_q_valid & (~rsp_q_valid | rsp.ready);
  assign req.ready = ~req_q_valid | advance;
  assign req_xfer  = req.valid & req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req.ready) begin
      req_q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q.op          <= req.op;
      req_q.addr        <= req.addr;
      req_q.hook_addr   <= req.hook_addr;
      req_q.patch_count <= req.patch_count;
      req_q.patch_ref   <= req.patch_ref;
    end
  end

  // compare, allocate and update the slots
  bpst_slots #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slots (
    .clk          (clk),
    .rst          (rst),
    .active_slots (active_slots),
    .req          (req_q),
    .fire         (advance),
    .rsp          (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_q_valid <= 1'b0;
    end else if (advance) begin
      rsp_q_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid           = rsp_q_valid;
  assign rsp.status          = rsp_q.status;
  assign rsp.slot            = rsp_q.slot;
  assign rsp.comp_word       = rsp_q.comp_word;
  assign rsp.hook_out        = rsp_q.hook_out;
  assign rsp.patch_count_out = rsp_q.patch_count_out;
  assign rsp.patch_ref_out   = rsp_q.patch_ref_out;

endmodule

[test/breakpoint_slot_table_core_tb.sv]
// self-checking testbench of the breakpoint slot table: set and lookup traffic against a predictor
module breakpoint_slot_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = bpst_pkg::MAX_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // receiver hold-off: starts once this many requests went in, lasts HOLD_CYCLES
  localparam int unsigned HOLD_AT = 400;
  localparam int unsigned HOLD_CYCLES = 200;
  // window of transfers with no idling on either side
  localparam int unsigned BURST_LO = 700;
  localparam int unsigned BURST_HI = 1000;
  localparam int unsigned IDLE_PCT = 8;
  localparam int unsigned SET_PCT = 5;
  localparam int unsigned PHASE_ITEMS = 118;

  // breakpoint table predictor plus queue of results still owed by the block
  class slot_table_scoreboard;
    logic [bpst_pkg::ACT_W-1:0]  active_cnt;
    bit                          slot_used [TABLE_SLOTS];
    logic [bpst_pkg::ADDR_W-1:0] slot_addr [TABLE_SLOTS];
    logic [bpst_pkg::HOOK_W-1:0] slot_hook [TABLE_SLOTS];
    logic [bpst_pkg::PCNT_W-1:0] slot_pcnt [TABLE_SLOTS];
    logic [bpst_pkg::PREF_W-1:0] slot_pref [TABLE_SLOTS];
    bpst_pkg::rsp_t              owed_results[$];
    int unsigned                 errors;
    int unsigned                 by_status [4];

    function new();
      active_cnt = bpst_pkg::ACTIVE_SLOTS_RST;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void set_active(logic [bpst_pkg::ACT_W-1:0] v);
      active_cnt = v;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // apply one accepted request to the table copy and queue its result
    function bpst_pkg::rsp_t note_request(bpst_pkg::req_t r);
      bpst_pkg::rsp_t              e;
      int unsigned                 n;
      int unsigned                 i;
      bit                          hit;
      logic [bpst_pkg::ADDR_W-1:0] a;
      n = (active_cnt > TABLE_SLOTS) ? TABLE_SLOTS : active_cnt;
      a = r.addr & bpst_pkg::ADDR_MASK;
      e = '0;
      hit = 1'b0;
      if (r.op == bpst_pkg::OP_SET) begin
        i = 0;
        while (i < n && slot_used[i]) i++;
        if (i >= n) begin
          e.status = bpst_pkg::ST_FULL;
        end else begin
          slot_used[i] = 1'b1;
          slot_addr[i] = a;
          slot_hook[i] = r.hook_addr;
          slot_pcnt[i] = r.patch_count;
          slot_pref[i] = r.patch_ref;
          e.status = bpst_pkg::ST_SET_DONE;
          e.slot = bpst_pkg::SLOT_W'(i);
          e.comp_word = a | bpst_pkg::COMP_ENABLE;
        end
      end else begin
        e.status = bpst_pkg::ST_NOT_FOUND;
        for (i = 0; i < n && slot_used[i] && !hit; i++) begin
          if (slot_addr[i] == a) begin
            hit = 1'b1;
            e.status = bpst_pkg::ST_FOUND;
            e.slot = bpst_pkg::SLOT_W'(i);
            e.hook_out = slot_hook[i];
            e.patch_count_out = slot_pcnt[i];
            e.patch_ref_out = slot_pref[i];
          end
        end
      end
      owed_results.push_back(e);
      by_status[e.status]++;
      return e;
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t: mismatch on %s, expected %h, actual %h", $time, field, exp_v, got_v);
      errors++;
    endfunction

    function void check_result(bpst_pkg::rsp_t got);
      bpst_pkg::rsp_t e;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (got.status !== e.status) report("status", e.status, got.status);
      if (got.slot !== e.slot) report("slot", e.slot, got.slot);
      if (got.comp_word !== e.comp_word) report("comp_word", e.comp_word, got.comp_word);
      if (got.hook_out !== e.hook_out) report("hook_out", e.hook_out, got.hook_out);
      if (got.patch_count_out !== e.patch_count_out)
        report("patch_count_out", e.patch_count_out, got.patch_count_out);
      if (got.patch_ref_out !== e.patch_ref_out)
        report("patch_ref_out", e.patch_ref_out, got.patch_ref_out);
    endfunction
  endclass

  logic clk;
  logic rst;

  bpst_cfg_if cfg_ch();
  bpst_req_if req_ch();
  bpst_rsp_if rsp_ch();

  breakpoint_slot_table_core #(.MAX_SLOTS(TABLE_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_table_scoreboard sb = new();

  int unsigned reqs_sent;
  int unsigned sets_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned cycles;
  // comparator addresses the table has actually taken, for lookups that hit
  logic [bpst_pkg::ADDR_W-1:0] stored_addrs[$];

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, counted in clock cycles
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("breakpoint_slot_table_core_tb: done, errors");
    $finish;
  end

  function automatic bpst_pkg::req_t make_req(logic op, logic [31:0] addr, logic [31:0] hook,
                                              logic [7:0] pcnt, logic [31:0] pref);
    bpst_pkg::req_t r;
    r.op = op;
    r.addr = addr;
    r.hook_addr = hook;
    r.patch_count = pcnt;
    r.patch_ref = pref;
    return r;
  endfunction

  // mostly lookups: stored addresses with either thumb bit, near misses one bit
  // away, and random noise; a few sets, some of them reusing a stored address
  function automatic bpst_pkg::req_t random_item();
    bpst_pkg::req_t r;
    int unsigned    pick;
    int unsigned    k;
    r.op = ($urandom_range(99) < SET_PCT) ? bpst_pkg::OP_SET : bpst_pkg::OP_LOOKUP;
    r.addr = $urandom();
    r.hook_addr = $urandom();
    r.patch_count = bpst_pkg::PCNT_W'($urandom());
    r.patch_ref = $urandom();
    pick = $urandom_range(99);
    if (stored_addrs.size() > 0) begin
      if (r.op == bpst_pkg::OP_LOOKUP && pick < 70) begin
        r.addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
        r.addr[0] = 1'($urandom_range(1));
        if (pick < 20) begin
          k = $urandom_range(bpst_pkg::ADDR_W - 1, 1);
          r.addr[k] = ~r.addr[k];
        end
      end else if (r.op == bpst_pkg::OP_SET && pick < 15) begin
        r.addr = stored_addrs[$urandom_range(stored_addrs.size() - 1)];
      end
    end
    return r;
  endfunction

  // offer one request, with random gaps outside the burst window
  task automatic send_req(input bpst_pkg::req_t r);
    bpst_pkg::rsp_t e;
    while ((reqs_sent < BURST_LO || reqs_sent >= BURST_HI) &&
           $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= r.op;
    req_ch.addr <= r.addr;
    req_ch.hook_addr <= r.hook_addr;
    req_ch.patch_count <= r.patch_count;
    req_ch.patch_ref <= r.patch_ref;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    e = sb.note_request(r);
    if (e.status == bpst_pkg::ST_SET_DONE) stored_addrs.push_back(r.addr & bpst_pkg::ADDR_MASK);
    if (r.op == bpst_pkg::OP_SET) sets_sent++;
    reqs_sent++;
  endtask

  // stop offering and wait until every owed result came back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // slot count write, only issued with the block empty
  task automatic write_active(input logic [bpst_pkg::ACT_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.active_slots <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_active(v);
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random ready, one long hold-off while the sender keeps going
  initial begin
    int unsigned    hold_left;
    bit             hold_done;
    bpst_pkg::rsp_t got;
    hold_left = 0;
    hold_done = 1'b0;
    results_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.slot = rsp_ch.slot;
        got.comp_word = rsp_ch.comp_word;
        got.hook_out = rsp_ch.hook_out;
        got.patch_count_out = rsp_ch.patch_count_out;
        got.patch_ref_out = rsp_ch.patch_ref_out;
        sb.check_result(got);
        results_seen++;
      end
      if (!hold_done && reqs_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (results_seen >= BURST_LO && results_seen < BURST_HI) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // main sequence
  initial begin
    // slot counts of the random phases: extremes, clamped values, lowering and raising
    logic [bpst_pkg::ACT_W-1:0] phase_cnt [14];
    phase_cnt = '{4'd2, 4'd8, 4'd4, 4'd0, 4'd9, 4'd3, 4'd15,
                  4'd5, 4'd1, 4'd8, 4'd6, 4'd12, 4'd7, 4'd8};
    reqs_sent = 0;
    sets_sent = 0;
    cfg_writes = 0;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.active_slots <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op <= bpst_pkg::OP_SET;
    req_ch.addr <= '0;
    req_ch.hook_addr <= '0;
    req_ch.patch_count <= '0;
    req_ch.patch_ref <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no usable slots: set is full, lookup misses
    write_active(4'd0);
    send_req(make_req(bpst_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'h0, 32'h0));
    drain();

    // one slot: fill it, second set is full, thumb bit ignored on lookup
    write_active(4'd1);
    send_req(make_req(bpst_pkg::OP_SET, 32'h0000_0001, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_SET, 32'h0000_0010, 32'h1234_5678, 8'h12, 32'h9ABC_DEF0));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF,
                      32'hFFFF_FFFF));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h0000_0002, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h0, 32'h0));
    drain();

    // count above the table size is clamped; duplicate address goes to the next slot
    write_active(4'd15);
    send_req(make_req(bpst_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_req(make_req(bpst_pkg::OP_SET, 32'hFFFF_FFFE, 32'hA5A5_5A5A, 8'h80, 32'h0000_0001));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0, 8'h0, 32'h0));
    drain();

    // count lowered: upper slots keep contents but are neither searched nor taken
    write_active(4'd1);
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h0, 32'h0));
    send_req(make_req(bpst_pkg::OP_SET, 32'h5555_5555, 32'h0, 8'h0, 32'h0));
    drain();
    write_active(4'd8);
    send_req(make_req(bpst_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'h0, 32'h0));
    drain();

    // random phases, one slot count each, block emptied before each write
    foreach (phase_cnt[p]) begin
      write_active(phase_cnt[p]);
      repeat (PHASE_ITEMS) send_req(random_item());
      drain();
    end

    repeat (6) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: results still owed, expected 0, actual %0d", $time, sb.pending());
      sb.errors++;
    end
    $display("covered %0d requests (%0d sets), %0d results, %0d slot count writes",
             reqs_sent, sets_sent, results_seen, cfg_writes);
    $display("results by status: set %0d, full %0d, found %0d, not found %0d",
             sb.by_status[bpst_pkg::ST_SET_DONE], sb.by_status[bpst_pkg::ST_FULL],
             sb.by_status[bpst_pkg::ST_FOUND], sb.by_status[bpst_pkg::ST_NOT_FOUND]);
    if (sb.errors == 0) begin
      $display("breakpoint_slot_table_core_tb: done, clean");
    end else begin
      $display("breakpoint_slot_table_core_tb: done, errors");
    end
    $finish;
  end

endmodule
